### rtl/cces_pkg.sv
// Shared types, constants and fixed-point helpers for the cardiac cell Euler step.
`default_nettype none
package cces_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_TIME_STEP     = 3'd0;
    localparam logic [2:0] CFG_EXCIT_GAIN    = 3'd1;
    localparam logic [2:0] CFG_THRESHOLD     = 3'd2;
    localparam logic [2:0] CFG_RECOV_OFFSET  = 3'd3;
    localparam logic [2:0] CFG_BASE_RATE     = 3'd4;
    localparam logic [2:0] CFG_RATE_NUM_GAIN = 3'd5;
    localparam logic [2:0] CFG_RATE_DEN_BIAS = 3'd6;

    localparam int FRAC_BITS = 16;

    // Q16.16 constants
    localparam logic signed [31:0] ONE_Q     = 32'sd65536;
    localparam logic signed [31:0] OFFSET_Q  = 32'sd5242880;   // 80.0
    localparam logic signed [31:0] K_ION     = 32'(((10000 << 16) + 64) / 129);
    localparam logic signed [31:0] K_REC     = 32'(((10 << 16) + 64) / 129);
    localparam logic signed [31:0] K_STIM    = 32'(((1 << 16) + 7) / 14);
    localparam logic signed [31:0] MAX_Q     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_Q     = 32'sh8000_0000;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for any x below 2^32
    localparam logic [31:0] RECIP_100   = 32'd2748779070;
    localparam int          RECIP_SHIFT = 38;

    // Pipeline shape
    localparam int FRONT_STAGES = 16;
    localparam int QUOT_W       = 48;
    localparam int DIV_BITS     = 2;
    localparam int DIV_STAGES   = QUOT_W / DIV_BITS;
    localparam int BACK_STAGES  = 9;
    localparam int PIPE_DEPTH   = 1 + FRONT_STAGES + DIV_STAGES + BACK_STAGES;
    localparam int STAGE_IDX_W  = 5;

    typedef struct packed {
        logic        f;
        logic signed [31:0] v;
    } sres_t;

    typedef struct packed {
        logic [20:0] dt;
        logic [21:0] c;
        logic [20:0] alpha;
        logic [20:0] b;
        logic [20:0] gamma;
        logic [20:0] mu1;
        logic [20:0] mu2;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] vin, r, stim, vn, v, d1, d2, den, vb;
        logic signed [31:0] cv, rv, num, t1, m2, g, vst;
        logic        [31:0] x;
        logic               sneg;
        logic signed [63:0] pa, pb, pc;
        logic               fault;
    } front_t;

    typedef struct packed {
        logic [30:0]        rem;
        logic [30:0]        dd;
        logic [QUOT_W-1:0]  dq;
        logic               neg;
        logic               bad;
        logic signed [31:0] vn, g, r;
        logic               fault;
    } div_t;

    typedef struct packed {
        logic signed [31:0] acc, vn, g, r;
        logic signed [63:0] pa;
        logic               fault;
    } back_t;

    function automatic logic signed [31:0] ux(input logic [21:0] u);
        ux = $signed({10'd0, u});
    endfunction

    function automatic sres_t sat33(input logic signed [32:0] x);
        sres_t o;
        o.f = 1'b0;
        o.v = x[31:0];
        if (x > $signed(33'h0_7FFF_FFFF)) begin
            o.f = 1'b1;
            o.v = MAX_Q;
        end else if (x < $signed(33'h1_8000_0000)) begin
            o.f = 1'b1;
            o.v = MIN_Q;
        end
        return o;
    endfunction

    function automatic sres_t add_s(input logic signed [31:0] a, input logic signed [31:0] b);
        add_s = sat33($signed({a[31], a}) + $signed({b[31], b}));
    endfunction

    function automatic sres_t sub_s(input logic signed [31:0] a, input logic signed [31:0] b);
        sub_s = sat33($signed({a[31], a}) - $signed({b[31], b}));
    endfunction

    function automatic logic signed [63:0] mul_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        mul_s = a * b;
    endfunction

    // round half away from zero to Q16.16, then saturate
    function automatic sres_t rnd_s(input logic signed [63:0] p);
        logic        neg;
        logic [63:0] m;
        logic [63:0] s;
        logic [47:0] q;
        sres_t       o;
        neg = p[63];
        m   = neg ? (~p + 64'd1) : p;
        s   = (m + 64'd32768) >> FRAC_BITS;
        q   = s[47:0];
        o.f = 1'b0;
        if (neg) begin
            if (q > 48'h0000_8000_0000) begin
                o.f = 1'b1;
                o.v = MIN_Q;
            end else begin
                o.v = $signed(~q[31:0] + 32'd1);
            end
        end else begin
            if (q > 48'h0000_7FFF_FFFF) begin
                o.f = 1'b1;
                o.v = MAX_Q;
            end else begin
                o.v = $signed(q[31:0]);
            end
        end
        return o;
    endfunction

    // Front section: normalization, cubic, recovery terms, voltage update
    function automatic front_t front_step(input logic [STAGE_IDX_W-1:0] idx,
                                          input cfg_t cfg, input front_t i);
        front_t             o;
        sres_t              t;
        sres_t              t2;
        sres_t              t3;
        logic        [25:0] q;
        o = i;
        case (idx)
            5'd1: begin
                t = add_s(i.vin, OFFSET_Q);
                o.vn = t.v;
                o.fault = i.fault | t.f;
                o.pa = mul_s(ux({1'b0, cfg.dt}), i.stim);
            end
            5'd2: begin
                o.sneg = i.vn[31];
                o.x = (i.vn[31] ? (~i.vn + 32'd1) : i.vn) + 32'd50;
                t = rnd_s(i.pa);
                o.vst = t.v;
                o.fault = i.fault | t.f;
            end
            5'd3: begin
                o.pa = $signed({32'd0, i.x} * {32'd0, RECIP_100});
                o.pb = mul_s(i.vst, K_STIM);
            end
            5'd4: begin
                q = i.pa[63:RECIP_SHIFT];
                o.v = i.sneg ? -$signed({6'd0, q}) : $signed({6'd0, q});
                t = rnd_s(i.pb);
                o.vst = t.v;
                o.fault = i.fault | t.f;
            end
            5'd5: begin
                o.pa = mul_s(ux(cfg.c), i.v);
                o.pb = mul_s(i.r, i.v);
                o.pc = mul_s(ux({1'b0, cfg.mu1}), i.r);
                t = sub_s(i.v, ux({1'b0, cfg.alpha}));
                o.d1 = t.v;
                t2 = sub_s(ONE_Q, i.v);
                o.d2 = t2.v;
                o.fault = i.fault | t.f | t2.f;
                t = add_s(ux({1'b0, cfg.mu2}), i.v);
                o.den = t.v;
                t2 = sub_s(i.v, ux({1'b0, cfg.b}));
                t3 = sub_s(t2.v, ONE_Q);
                o.vb = t3.v;
                o.fault = o.fault | t.f | t2.f | t3.f;
            end
            5'd6: begin
                t = rnd_s(i.pa);
                t2 = rnd_s(i.pb);
                t3 = rnd_s(i.pc);
                o.cv = t.v;
                o.rv = t2.v;
                o.num = t3.v;
                o.fault = i.fault | t.f | t2.f | t3.f;
            end
            5'd7: begin
                o.pa = mul_s(i.cv, i.d1);
                o.pb = mul_s(i.cv, i.vb);
            end
            5'd8: begin
                t = rnd_s(i.pa);
                t2 = rnd_s(i.pb);
                o.t1 = t.v;
                o.m2 = t2.v;
                o.fault = i.fault | t.f | t2.f;
            end
            5'd9: begin
                o.pa = mul_s(i.t1, i.d2);
                t = sub_s(32'sd0, i.r);
                t2 = sub_s(t.v, i.m2);
                o.g = t2.v;
                o.fault = i.fault | t.f | t2.f;
            end
            5'd10: begin
                t = rnd_s(i.pa);
                o.t1 = t.v;
                o.fault = i.fault | t.f;
            end
            5'd11: begin
                t = sub_s(i.rv, i.t1);     // ion current
                o.rv = t.v;
                o.fault = i.fault | t.f;
            end
            5'd12: o.pa = mul_s(ux({1'b0, cfg.dt}), i.rv);
            5'd13: begin
                t = rnd_s(i.pa);
                o.t1 = t.v;
                o.fault = i.fault | t.f;
            end
            5'd14: o.pa = mul_s(i.t1, K_ION);
            5'd15: begin
                t = rnd_s(i.pa);
                o.t1 = t.v;
                o.fault = i.fault | t.f;
            end
            5'd16: begin
                t = sub_s(i.vin, i.t1);
                t2 = sub_s(t.v, i.vst);
                o.vn = t2.v;
                o.fault = i.fault | t.f | t2.f;
            end
            default: o = i;
        endcase
        return o;
    endfunction

    // Restoring division, DIV_BITS quotient bits per stage
    function automatic div_t div_step(input div_t i);
        div_t        o;
        logic [31:0] rs;
        o = i;
        for (int k = 0; k < DIV_BITS; k++) begin
            rs = {o.rem, o.dq[QUOT_W-1]};
            o.dq = {o.dq[QUOT_W-2:0], 1'b0};
            if (rs >= {1'b0, o.dd}) begin
                rs = rs - {1'b0, o.dd};
                o.dq[0] = 1'b1;
            end
            o.rem = rs[30:0];
        end
        return o;
    endfunction

    // Recovery section: rate, reaction term, recovery update
    function automatic back_t back_step(input logic [STAGE_IDX_W-1:0] idx,
                                        input cfg_t cfg, input back_t i);
        back_t o;
        sres_t t;
        o = i;
        case (idx)
            5'd2: begin
                t = add_s(ux({1'b0, cfg.gamma}), i.acc);
                o.acc = t.v;
                o.fault = i.fault | t.f;
            end
            5'd3: o.pa = mul_s(i.acc, i.g);
            5'd5: o.pa = mul_s(ux({1'b0, cfg.dt}), i.acc);
            5'd7: o.pa = mul_s(i.acc, K_REC);
            5'd4, 5'd6, 5'd8: begin
                t = rnd_s(i.pa);
                o.acc = t.v;
                o.fault = i.fault | t.f;
            end
            5'd9: begin
                t = add_s(i.r, i.acc);
                o.acc = t.v;
                o.fault = i.fault | t.f;
            end
            default: o = i;
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

### rtl/cces_div_pipe.sv
// Pipelined restoring divider for the recovery rate quotient.
`default_nettype none
module cces_div_pipe (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire cces_pkg::div_t din,
    output cces_pkg::div_t      dout
);
    import cces_pkg::*;

    div_t st_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= div_step(din);
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= div_step(st_reg[k-1]);
            end
        end
    end

    assign dout = st_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

### rtl/cardiac_cell_euler_step.sv
// Top level: one explicit Euler step of the Aliev-Panfilov cell model per request.
//
// Takes one mesh node per request (voltage in mV, recovery variable, stimulus
// current, all signed Q16.16) and returns the voltage and recovery value after
// one Euler step plus a fault flag that is set when any saturation happened
// or the recovery rate denominator (mu2 + V) was zero or negative. A new
// request can be taken every clock while the pipe is not held; the pipe is 50
// register stages deep, input register to result register. The depth is
// set by the rate quotient divider, 24 stages of two quotient bits each, behind
// an input register and a 16-stage front section and ahead of a 9-stage back
// section whose stages are each at most one 32x32 multiply or one
// rounding/saturation step deep. The whole pipe advances together: it only
// holds when the result register is full and not taken, so s_tready follows
// m_tready combinationally. Coefficients come from the register write port
// and must only be changed while no request is in flight.
`default_nettype none
module cardiac_cell_euler_step (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,  // membrane_voltage, recovery_value, stimulus_current
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,  // next_voltage, next_recovery, range_fault, zero pad
    // register write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_addr,
    input  wire logic [21:0] cfg_wr_data
);
    import cces_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;

    cfg_t   cfg_reg;
    logic   [PIPE_DEPTH-1:0] valid_reg;
    logic   en;
    logic   in_acc;
    front_t fr_in;
    front_t fr_reg [FRONT_STAGES+1];
    div_t   div_in;
    div_t   div_out;
    back_t  bk_first;
    back_t  bk_reg [1:BACK_STAGES];

    // Whole pipe moves unless the result register holds an untaken result
    assign en       = !valid_reg[LAST] || m_tready;
    assign s_tready = en;
    assign in_acc   = s_tvalid && s_tready;

    // Coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dt    <= 21'd655;
            cfg_reg.c     <= 22'd524288;
            cfg_reg.alpha <= 21'd655;
            cfg_reg.b     <= 21'd9830;
            cfg_reg.gamma <= 21'd131;
            cfg_reg.mu1   <= 21'd13107;
            cfg_reg.mu2   <= 21'd19661;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                CFG_TIME_STEP:     cfg_reg.dt    <= cfg_wr_data[20:0];
                CFG_EXCIT_GAIN:    cfg_reg.c     <= cfg_wr_data;
                CFG_THRESHOLD:     cfg_reg.alpha <= cfg_wr_data[20:0];
                CFG_RECOV_OFFSET:  cfg_reg.b     <= cfg_wr_data[20:0];
                CFG_BASE_RATE:     cfg_reg.gamma <= cfg_wr_data[20:0];
                CFG_RATE_NUM_GAIN: cfg_reg.mu1   <= cfg_wr_data[20:0];
                CFG_RATE_DEN_BIAS: cfg_reg.mu2   <= cfg_wr_data[20:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // Valid bits travel alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_acc};
        end
    end

    // Input capture
    always_comb begin
        fr_in      = '0;
        fr_in.vin  = $signed(s_tdata[31:0]);
        fr_in.r    = $signed(s_tdata[63:32]);
        fr_in.stim = $signed(s_tdata[95:64]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fr_reg[0] <= fr_in;
        end
    end

    // Front section: V, cubic, ion term and voltage update
    for (genvar k = 1; k <= FRONT_STAGES; k++) begin : g_front
        always_ff @(posedge aclk) begin
            if (en) begin
                fr_reg[k] <= front_step(STAGE_IDX_W'(k), cfg_reg, fr_reg[k-1]);
            end
        end
    end

    // Divider setup: |mu1*r| << 16 over (mu2 + V); nonpositive divisor flagged
    always_comb begin
        div_in       = '0;
        div_in.neg   = fr_reg[FRONT_STAGES].num[31];
        div_in.bad   = fr_reg[FRONT_STAGES].den[31] || (fr_reg[FRONT_STAGES].den == 32'sd0);
        div_in.dd    = div_in.bad ? 31'd1 : fr_reg[FRONT_STAGES].den[30:0];
        div_in.dq    = {(div_in.neg ? (~fr_reg[FRONT_STAGES].num + 32'd1)
                                    : fr_reg[FRONT_STAGES].num), 16'd0};
        div_in.vn    = fr_reg[FRONT_STAGES].vn;
        div_in.g     = fr_reg[FRONT_STAGES].g;
        div_in.r     = fr_reg[FRONT_STAGES].r;
        div_in.fault = fr_reg[FRONT_STAGES].fault;
    end

    cces_div_pipe u_div (
        .aclk (aclk),
        .en   (en),
        .din  (div_in),
        .dout (div_out)
    );

    // Quotient rounding and saturation
    always_comb begin
        logic [QUOT_W:0] q;
        q = {1'b0, div_out.dq};
        if ({div_out.rem, 1'b0} >= {1'b0, div_out.dd}) begin
            q = q + 49'd1;
        end
        bk_first       = '0;
        bk_first.vn    = div_out.vn;
        bk_first.g     = div_out.g;
        bk_first.r     = div_out.r;
        bk_first.fault = div_out.fault;
        if (div_out.bad) begin
            bk_first.acc   = div_out.neg ? MIN_Q : MAX_Q;
            bk_first.fault = 1'b1;
        end else if (div_out.neg) begin
            if (q > 49'h0_0000_8000_0000) begin
                bk_first.acc   = MIN_Q;
                bk_first.fault = 1'b1;
            end else begin
                bk_first.acc = $signed(~q[31:0] + 32'd1);
            end
        end else begin
            if (q > 49'h0_0000_7FFF_FFFF) begin
                bk_first.acc   = MAX_Q;
                bk_first.fault = 1'b1;
            end else begin
                bk_first.acc = $signed(q[31:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bk_reg[1] <= bk_first;
        end
    end

    // Back section: rate * g, dt scaling, recovery update; last stage is the result register
    for (genvar k = 2; k <= BACK_STAGES; k++) begin : g_back
        always_ff @(posedge aclk) begin
            if (en) begin
                bk_reg[k] <= back_step(STAGE_IDX_W'(k), cfg_reg, bk_reg[k-1]);
            end
        end
    end

    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = {7'd0, bk_reg[BACK_STAGES].fault, bk_reg[BACK_STAGES].acc,
                       bk_reg[BACK_STAGES].vn};

    // A held result freezes the whole pipe
    a_hold_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(valid_reg))
        else $error("pipe moved while the result was held");

    // Requests in flight are conserved when nothing enters or leaves
    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        en && !in_acc && !valid_reg[LAST]
        |=> $countones(valid_reg) == $past($countones(valid_reg)))
        else $error("request lost or invented in the pipe");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire
